### rtl/integer_literal_parser_assert.svh
// Assertion macros shared by the integer literal parser RTL.
// Needs clk_i and rst_ni in the scope of every module that uses them.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// Check a property on every rising edge, ignored while reset is asserted.
`define ILP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ILP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
// No dependencies; used by ilp_accum, ilp_final and integer_literal_parser.
`timescale 1ns / 1ps

package ilp_pkg;

  // Characters the parser recognizes
  localparam logic [7:0] CH_X_LC = 8'h78;  // x
  localparam logic [7:0] CH_O_LC = 8'h6F;  // o
  localparam logic [7:0] CH_B_LC = 8'h62;  // b
  localparam logic [7:0] CH_I_LC = 8'h69;  // i
  localparam logic [7:0] CH_I_UC = 8'h49;  // I
  localparam logic [7:0] CH_U_LC = 8'h75;  // u
  localparam logic [7:0] CH_U_UC = 8'h55;  // U
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_8    = 8'h38;

  localparam int unsigned ValueW = 64;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_e;

  typedef enum logic [2:0] {
    T_I8  = 3'd0,
    T_I16 = 3'd1,
    T_I32 = 3'd2,
    T_I64 = 3'd3,
    T_U8  = 3'd4,
    T_U16 = 3'd5,
    T_U32 = 3'd6,
    T_U64 = 3'd7
  } type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_SFX  = 2'd2
  } status_e;

  // Parse state at the final character, handed to the result stage
  typedef struct packed {
    logic [ValueW-1:0] accum;
    logic              wide_ovf;
    logic              in_sfx;
    logic              sfx_uns;
    logic [15:0]       sfx_chars;
    logic [1:0]        sfx_cnt;
  } snap_t;

endpackage

### rtl/ilp_accum.sv
// Per-character parse stage: prefix, digit accumulation and suffix capture.
// Depends on ilp_pkg and integer_literal_parser_assert.svh.
`timescale 1ns / 1ps
`include "integer_literal_parser_assert.svh"

module ilp_accum (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    char_i,
  input  logic          last_i,
  output ilp_pkg::snap_t snap_o
);

  localparam int unsigned W = ilp_pkg::ValueW;

  logic              at_first_q, at_first_d;
  ilp_pkg::radix_e   radix_q, radix_d;
  logic [W-1:0]      accum_q, accum_d;
  logic              wide_ovf_q, wide_ovf_d;
  logic              stopped_q, stopped_d;
  logic              in_sfx_q, in_sfx_d;
  logic              sfx_uns_q, sfx_uns_d;
  logic [15:0]       sfx_chars_q, sfx_chars_d;
  logic [1:0]        sfx_cnt_q, sfx_cnt_d;

  logic [3:0]        dig;
  logic              dig_vld;
  logic              dig_ok;
  logic [W+3:0]      prod;
  logic [W+3:0]      sum;
  logic              is_sfx_char;

  // Digit value of a character, any base up to 16
  always_comb begin
    dig     = 4'd0;
    dig_vld = 1'b0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      dig     = 4'(char_i - 8'h30);
      dig_vld = 1'b1;
    end else if (char_i >= 8'h61 && char_i <= 8'h66) begin
      dig     = 4'(char_i - 8'h57);
      dig_vld = 1'b1;
    end else if (char_i >= 8'h41 && char_i <= 8'h46) begin
      dig     = 4'(char_i - 8'h37);
      dig_vld = 1'b1;
    end
  end

  // Scale by the radix with shifts; decimal is x8 + x2
  always_comb begin
    dig_ok = 1'b0;
    prod   = '0;
    unique case (radix_q)
      ilp_pkg::RADIX_HEX: begin
        dig_ok = dig_vld;
        prod   = {accum_q, 4'b0};
      end
      ilp_pkg::RADIX_OCT: begin
        dig_ok = dig_vld && (dig < 4'd8);
        prod   = {1'b0, accum_q, 3'b0};
      end
      ilp_pkg::RADIX_BIN: begin
        dig_ok = dig_vld && (dig < 4'd2);
        prod   = {3'b0, accum_q, 1'b0};
      end
      default: begin
        dig_ok = dig_vld && (dig < 4'd10);
        prod   = {1'b0, accum_q, 3'b0} + {3'b0, accum_q, 1'b0};
      end
    endcase
  end

  assign sum = prod + {{W{1'b0}}, dig};

  assign is_sfx_char = (char_i == ilp_pkg::CH_I_LC) || (char_i == ilp_pkg::CH_I_UC) ||
                       (char_i == ilp_pkg::CH_U_LC) || (char_i == ilp_pkg::CH_U_UC);

  always_comb begin
    at_first_d  = 1'b0;
    radix_d     = radix_q;
    accum_d     = accum_q;
    wide_ovf_d  = wide_ovf_q;
    stopped_d   = stopped_q;
    in_sfx_d    = in_sfx_q;
    sfx_uns_d   = sfx_uns_q;
    sfx_chars_d = sfx_chars_q;
    sfx_cnt_d   = sfx_cnt_q;
    if (in_sfx_q) begin
      if (sfx_cnt_q < 2'd2) begin
        sfx_chars_d = {sfx_chars_q[7:0], char_i};
      end
      if (sfx_cnt_q != 2'd3) begin
        sfx_cnt_d = sfx_cnt_q + 2'd1;
      end
    end else if (is_sfx_char) begin
      in_sfx_d  = 1'b1;
      sfx_uns_d = (char_i == ilp_pkg::CH_U_LC) || (char_i == ilp_pkg::CH_U_UC);
      stopped_d = 1'b1;
    end else if (at_first_q && char_i == ilp_pkg::CH_X_LC) begin
      radix_d = ilp_pkg::RADIX_HEX;
    end else if (at_first_q && char_i == ilp_pkg::CH_O_LC) begin
      radix_d = ilp_pkg::RADIX_OCT;
    end else if (at_first_q && char_i == ilp_pkg::CH_B_LC) begin
      radix_d = ilp_pkg::RADIX_BIN;
    end else if (!stopped_q) begin
      if (dig_ok) begin
        if (!wide_ovf_q) begin
          if (|sum[W+3:W]) begin
            wide_ovf_d = 1'b1;
          end else begin
            accum_d = sum[W-1:0];
          end
        end
      end else begin
        stopped_d = 1'b1;
      end
    end
  end

  always_comb begin
    snap_o.accum     = accum_d;
    snap_o.wide_ovf  = wide_ovf_d;
    snap_o.in_sfx    = in_sfx_d;
    snap_o.sfx_uns   = sfx_uns_d;
    snap_o.sfx_chars = sfx_chars_d;
    snap_o.sfx_cnt   = sfx_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_first_q  <= 1'b1;
      radix_q     <= ilp_pkg::RADIX_DEC;
      accum_q     <= '0;
      wide_ovf_q  <= 1'b0;
      stopped_q   <= 1'b0;
      in_sfx_q    <= 1'b0;
      sfx_uns_q   <= 1'b0;
      sfx_chars_q <= '0;
      sfx_cnt_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        at_first_q  <= 1'b1;
        radix_q     <= ilp_pkg::RADIX_DEC;
        accum_q     <= '0;
        wide_ovf_q  <= 1'b0;
        stopped_q   <= 1'b0;
        in_sfx_q    <= 1'b0;
        sfx_uns_q   <= 1'b0;
        sfx_chars_q <= '0;
        sfx_cnt_q   <= '0;
      end else begin
        at_first_q  <= at_first_d;
        radix_q     <= radix_d;
        accum_q     <= accum_d;
        wide_ovf_q  <= wide_ovf_d;
        stopped_q   <= stopped_d;
        in_sfx_q    <= in_sfx_d;
        sfx_uns_q   <= sfx_uns_d;
        sfx_chars_q <= sfx_chars_d;
        sfx_cnt_q   <= sfx_cnt_d;
      end
    end
  end

  `ILP_ASSERT(a_accum_frozen_on_ovf, (wide_ovf_q && step_i && !last_i) |=> $stable(accum_q), "accumulator moved after 64-bit overflow")
  `ILP_ASSERT(a_stop_sticky, (stopped_q && !(step_i && last_i)) |=> stopped_q, "digit stop cleared inside a literal")

endmodule

### rtl/ilp_final.sv
// Result stage: suffix decode, range check and saturation, output register.
// Depends on ilp_pkg and integer_literal_parser_assert.svh.
`timescale 1ns / 1ps
`include "integer_literal_parser_assert.svh"

module ilp_final (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         snap_vld_i,
  input  ilp_pkg::snap_t               snap_i,
  output logic                         snap_rdy_o,
  output logic                         out_vld_o,
  input  logic                         out_rdy_i,
  output logic [ilp_pkg::ValueW-1:0]   value_o,
  output logic [2:0]                   type_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned W = ilp_pkg::ValueW;

  ilp_pkg::snap_t    snap_q;
  logic              snap_vld_q, snap_vld_d;
  logic              out_vld_q, out_vld_d;
  logic [W-1:0]      value_q;
  ilp_pkg::type_e    type_q;
  ilp_pkg::status_e  status_q;

  logic              out_load;
  logic [7:0]        hi, lo;
  logic              bad;
  ilp_pkg::type_e    ty;
  logic [W-1:0]      mx;
  logic [W-1:0]      res_value;
  ilp_pkg::type_e    res_type;
  ilp_pkg::status_e  res_status;

  function automatic logic [W-1:0] type_max(ilp_pkg::type_e t);
    logic [W-1:0] m;
    unique case (t)
      ilp_pkg::T_I8:  m = W'(64'h7F);
      ilp_pkg::T_I16: m = W'(64'h7FFF);
      ilp_pkg::T_I32: m = W'(64'h7FFF_FFFF);
      ilp_pkg::T_I64: m = {1'b0, {(W-1){1'b1}}};
      ilp_pkg::T_U8:  m = W'(64'hFF);
      ilp_pkg::T_U16: m = W'(64'hFFFF);
      ilp_pkg::T_U32: m = W'(64'hFFFF_FFFF);
      default:        m = {W{1'b1}};
    endcase
    return m;
  endfunction

  assign out_load   = snap_vld_q && (!out_vld_q || out_rdy_i);
  assign snap_rdy_o = !snap_vld_q || !out_vld_q || out_rdy_i;

  assign hi = snap_q.sfx_chars[15:8];
  assign lo = snap_q.sfx_chars[7:0];

  always_comb begin
    ty  = ilp_pkg::T_I32;
    bad = 1'b0;
    if (snap_q.in_sfx) begin
      if (snap_q.sfx_cnt == 2'd1 && lo == ilp_pkg::CH_8) begin
        ty = ilp_pkg::T_I8;
      end else if (snap_q.sfx_cnt == 2'd2 && hi == ilp_pkg::CH_1 && lo == ilp_pkg::CH_6) begin
        ty = ilp_pkg::T_I16;
      end else if (snap_q.sfx_cnt == 2'd2 && hi == ilp_pkg::CH_3 && lo == ilp_pkg::CH_2) begin
        ty = ilp_pkg::T_I32;
      end else if (snap_q.sfx_cnt == 2'd2 && hi == ilp_pkg::CH_6 && lo == ilp_pkg::CH_4) begin
        ty = ilp_pkg::T_I64;
      end else begin
        bad = 1'b1;
      end
      if (!bad && snap_q.sfx_uns) begin
        ty = ilp_pkg::type_e'({1'b1, ty[1:0]});
      end
    end
  end

  assign mx = type_max(ty);

  always_comb begin
    if (bad) begin
      res_value  = '0;
      res_type   = ilp_pkg::T_I32;
      res_status = ilp_pkg::ST_BAD_SFX;
    end else if (snap_q.wide_ovf || snap_q.accum > mx) begin
      res_value  = mx;
      res_type   = ty;
      res_status = ilp_pkg::ST_OVERFLOW;
    end else begin
      res_value  = snap_q.accum;
      res_type   = ty;
      res_status = ilp_pkg::ST_OK;
    end
  end

  always_comb begin
    snap_vld_d = snap_vld_q;
    if (snap_vld_i && snap_rdy_o) begin
      snap_vld_d = 1'b1;
    end else if (out_load) begin
      snap_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_rdy_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      snap_vld_q <= snap_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_vld_i && snap_rdy_o) begin
      snap_q <= snap_i;
    end
    if (out_load) begin
      value_q  <= res_value;
      type_q   <= res_type;
      status_q <= res_status;
    end
  end

  assign out_vld_o = out_vld_q;
  assign value_o   = value_q;
  assign type_o    = type_q;
  assign status_o  = status_q;

  `ILP_ASSERT(a_ok_in_range, (out_vld_q && status_q == ilp_pkg::ST_OK) |-> (value_q <= type_max(type_q)), "ok result above type maximum")
  `ILP_ASSERT(a_bad_sfx_fields, (out_vld_q && status_q == ilp_pkg::ST_BAD_SFX) |-> (value_q == '0 && type_q == ilp_pkg::T_I32), "bad suffix result not zero i32")
  `ILP_ASSERT_NEVER(a_snap_overrun, snap_vld_i && !snap_rdy_o && out_load, "snapshot stage ready logic inconsistent")

endmodule

### rtl/integer_literal_parser.sv
// Top level of the integer literal parser: input register, parse and result stages.
// Depends on ilp_pkg, ilp_accum, ilp_final and integer_literal_parser_assert.svh.
`timescale 1ns / 1ps
`include "integer_literal_parser_assert.svh"

// Usage:
//   Feed a literal on the slave stream one ASCII character per transaction,
//   with s_axis_tlast high on its final character. A leading x, o or b picks
//   base 16, 8 or 2; digits build a 64-bit magnitude; i/u plus 8, 16, 32 or 64
//   set the type (i32 when absent). One result transaction per literal leaves
//   on the master stream carrying value, type code and status.
//   Throughput: one character per cycle unless a last character is held
//   (see Stall), set by the multiply-by-radix (shift-add) and 68-bit carry
//   check in ilp_accum. A literal's end: the last character moves from the
//   input register through the parse stage into the snapshot register, then
//   into the result register, which drives m_axis_tvalid.
//   Reset: clears every valid flag and the parse state; the first character
//   after reset starts a new literal in base 10.
//   Stall: while m_axis_tready is low, one result and one more snapshot can
//   wait in ilp_final; once both are full, a pending last character holds in
//   the input register and s_axis_tready drops. Characters that are not last
//   keep flowing until such a last character reaches the input register.

module integer_literal_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [63:0] value, [66:64] type_code, [68:67] status
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_char_q;
  logic        in_last_q;

  logic        snap_rdy;
  logic        step_go;
  logic        step;
  logic        snap_load;
  ilp_pkg::snap_t snap;

  logic [ilp_pkg::ValueW-1:0] value;
  logic [2:0]  type_code;
  logic [1:0]  status;

  // Non-last characters always advance; a last one waits for the result stage
  assign step_go       = !in_last_q || snap_rdy;
  assign step          = in_vld_q && step_go;
  assign snap_load     = step && in_last_q;
  assign s_axis_tready = !in_vld_q || step_go;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready) begin
      in_vld_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Capture the character payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ilp_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .snap_o (snap)
  );

  ilp_final u_final (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_vld_i (snap_load),
    .snap_i     (snap),
    .snap_rdy_o (snap_rdy),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .value_o    (value),
    .type_o     (type_code),
    .status_o   (status)
  );

  assign m_axis_tdata = {3'b000, status, type_code, value};

  // A last character that cannot advance must stay put in the input register
  `ILP_ASSERT(a_hold_last, (in_vld_q && in_last_q && !snap_rdy) |=> (in_vld_q && in_last_q), "last character dropped while result stage busy")

endmodule
